// ===== rtl/wshc_pkg.sv =====
// Shared types and constants for the window size hint constraint block.
// No dependencies; compiled first.
package wshc_pkg;

   localparam int HALF_W       = 16;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int FLAGS_W      = 5;
   localparam int UNBOUND_LOG2 = 40;

   localparam int FLAG_MIN    = 0;
   localparam int FLAG_MAX    = 1;
   localparam int FLAG_INC    = 2;
   localparam int FLAG_ASPECT = 3;
   localparam int FLAG_BASE   = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HINT_FLAGS   = 3'd0,
      CSR_MIN_SIZE     = 3'd1,
      CSR_BASE_SIZE    = 3'd2,
      CSR_MAX_SIZE     = 3'd3,
      CSR_SIZE_STEP    = 3'd4,
      CSR_LEAST_ASPECT = 3'd5,
      CSR_MOST_ASPECT  = 3'd6
   } csr_idx_type;

   localparam logic [FLAGS_W-1:0]    RST_FLAGS  = '0;
   localparam logic [CSR_DATA_W-1:0] RST_MIN    = 32'h0001_0001;
   localparam logic [CSR_DATA_W-1:0] RST_BASE   = 32'h0000_0000;
   localparam logic [CSR_DATA_W-1:0] RST_MAX    = 32'h7FFF_7FFF;
   localparam logic [CSR_DATA_W-1:0] RST_STEP   = 32'h0001_0001;
   localparam logic [CSR_DATA_W-1:0] RST_ASPECT = 32'h0001_0001;

endpackage

// ===== rtl/wshc_req_if.sv =====
// Request channel: valid/ready handshake carrying the wanted size.
// No dependencies.
interface wshc_req_if #(parameter int DIM_BITS = 16);
   logic                       valid;
   logic                       ready;
   logic signed [DIM_BITS-1:0] request_width;
   logic signed [DIM_BITS-1:0] request_height;
   modport source (output valid, request_width, request_height, input ready);
   modport sink   (input valid, request_width, request_height, output ready);
endinterface

// ===== rtl/wshc_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the legal size.
// No dependencies.
interface wshc_rsp_if #(parameter int DIM_BITS = 16);
   logic                       valid;
   logic                       ready;
   logic signed [DIM_BITS-1:0] legal_width;
   logic signed [DIM_BITS-1:0] legal_height;
   modport source (output valid, legal_width, legal_height, input ready);
   modport sink   (input valid, legal_width, legal_height, output ready);
endinterface

// ===== rtl/wshc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on wshc_pkg (HALF_W).
module wshc_div import wshc_pkg::*; #(
   parameter int NUM_W = 32,
   parameter int PAY_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [HALF_W-1:0] den,
   input  logic [PAY_W-1:0]  in_pay,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quo,
   output logic [HALF_W-1:0] rem,
   output logic [PAY_W-1:0]  out_pay
);

   logic [NUM_W-1:0]  valid_ff;
   logic [HALF_W-1:0] rem_ff  [NUM_W];
   logic [NUM_W-1:0]  work_ff [NUM_W];
   logic [PAY_W-1:0]  pay_ff  [NUM_W];
   logic [HALF_W-1:0] rem_in  [NUM_W];
   logic [NUM_W-1:0]  work_in [NUM_W];

   always_comb begin
      logic [HALF_W-1:0] r_src;
      logic [NUM_W-1:0]  w_src;
      logic [HALF_W:0]   trial;
      logic [HALF_W:0]   diff;
      for (int s = 0; s < NUM_W; s++) begin
         if (s == 0) begin
            r_src = '0;
            w_src = num;
         end else begin
            r_src = rem_ff[s-1];
            w_src = work_ff[s-1];
         end
         trial      = {r_src, w_src[NUM_W-1]};
         diff       = trial - {1'b0, den};
         rem_in[s]  = diff[HALF_W] ? trial[HALF_W-1:0] : diff[HALF_W-1:0];
         work_in[s] = {w_src[NUM_W-2:0], ~diff[HALF_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NUM_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NUM_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
            pay_ff[s]  <= (s == 0) ? in_pay : pay_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign quo       = work_ff[NUM_W-1];
   assign rem       = rem_ff[NUM_W-1];
   assign out_pay   = pay_ff[NUM_W-1];

endmodule

// ===== rtl/window_size_hint_constrain_top.sv =====
// Channel   | dir | handshake      | word
// req_chan  | in  | valid / ready  | request_width, request_height
// rsp_chan  | out | valid / ready  | legal_width, legal_height
// csr_*     | in  | csr_wr_en      | csr_index, csr_wdata
// One word accepted per cycle while rsp_chan is not stalled; the size passes through
// pipelined divider pairs in series: snap, aspect 1, step 1, aspect 2, step 2.
// Synchronous reset clears stage valids and loads the register defaults.
// A stall on rsp_chan freezes every stage together; req_chan.ready follows.
// Depends on wshc_pkg, wshc_req_if, wshc_rsp_if and wshc_div.
module window_size_hint_constrain_top import wshc_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   wshc_req_if.sink               req_chan,
   wshc_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int UW = (DIM_BITS - 1 > HALF_W) ? DIM_BITS - 1 : HALF_W;
   localparam int A  = ((UW > UNBOUND_LOG2) ? UW : UNBOUND_LOG2) + 1;
   localparam int M1 = UW + HALF_W;
   localparam int M2 = A + HALF_W;
   localparam int XW = M2 + 1;
   localparam int SW = UW + 2;
   localparam logic [XW-1:0] UNBOUNDED = XW'(1) << UNBOUND_LOG2;
   localparam logic [A-1:0]  OUT_MAX   = (A'(1) << (DIM_BITS - 1)) - A'(1);

   // registers
   logic [FLAGS_W-1:0]    flags_ff;
   logic [CSR_DATA_W-1:0] min_ff, base_ff, max_ff, step_ff, lasp_ff, masp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= RST_FLAGS;
         min_ff   <= RST_MIN;
         base_ff  <= RST_BASE;
         max_ff   <= RST_MAX;
         step_ff  <= RST_STEP;
         lasp_ff  <= RST_ASPECT;
         masp_ff  <= RST_ASPECT;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_HINT_FLAGS:   flags_ff <= csr_wdata[FLAGS_W-1:0];
            CSR_MIN_SIZE:     min_ff   <= csr_wdata;
            CSR_BASE_SIZE:    base_ff  <= csr_wdata;
            CSR_MAX_SIZE:     max_ff   <= csr_wdata;
            CSR_SIZE_STEP:    step_ff  <= csr_wdata;
            CSR_LEAST_ASPECT: lasp_ff  <= csr_wdata;
            CSR_MOST_ASPECT:  masp_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective hints
   logic [HALF_W-1:0] min_w, min_h, base_w, base_h, inc_w, inc_h, raw_iw, raw_ih;
   logic [HALF_W-1:0] ax, ay, bx, by;
   logic [XW-1:0]     lim_w, lim_h;
   logic              has_max, asp1_on, asp2_on;

   always_comb begin
      if (flags_ff[FLAG_MIN]) begin
         min_w = min_ff[15:0];
         min_h = min_ff[31:16];
      end else if (flags_ff[FLAG_BASE]) begin
         min_w = base_ff[15:0];
         min_h = base_ff[31:16];
      end else begin
         min_w = HALF_W'(1);
         min_h = HALF_W'(1);
      end
      if (flags_ff[FLAG_BASE]) begin
         base_w = base_ff[15:0];
         base_h = base_ff[31:16];
      end else if (flags_ff[FLAG_MIN]) begin
         base_w = min_ff[15:0];
         base_h = min_ff[31:16];
      end else begin
         base_w = '0;
         base_h = '0;
      end
      has_max = flags_ff[FLAG_MAX];
      lim_w   = has_max ? XW'(max_ff[15:0])  : UNBOUNDED;
      lim_h   = has_max ? XW'(max_ff[31:16]) : UNBOUNDED;
      raw_iw  = flags_ff[FLAG_INC] ? step_ff[15:0]  : HALF_W'(1);
      raw_ih  = flags_ff[FLAG_INC] ? step_ff[31:16] : HALF_W'(1);
      inc_w   = (raw_iw == '0) ? HALF_W'(1) : raw_iw;
      inc_h   = (raw_ih == '0) ? HALF_W'(1) : raw_ih;
      ax      = lasp_ff[15:0];
      ay      = lasp_ff[31:16];
      bx      = masp_ff[15:0];
      by      = masp_ff[31:16];
      asp1_on = flags_ff[FLAG_ASPECT] && (ax != '0) && (ay != '0);
      asp2_on = flags_ff[FLAG_ASPECT] && (bx != '0) && (by != '0);
   end

   function automatic logic [UW-1:0] clamp_dim(input logic signed [DIM_BITS-1:0] v,
                                                input logic [HALF_W-1:0] lo,
                                                input logic [HALF_W-1:0] hi,
                                                input logic hi_on);
      logic signed [SW-1:0] x;
      logic signed [SW-1:0] lo_s;
      logic signed [SW-1:0] hi_s;
      x    = SW'(v);
      lo_s = signed'(SW'(lo));
      hi_s = signed'(SW'(hi));
      if (x < lo_s) x = lo_s;
      if (hi_on && x > hi_s) x = hi_s;
      return x[UW-1:0];
   endfunction

   logic adv;
   logic out_valid_ff;
   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 0: input capture; stage 1: clamp
   logic                       s0_valid_ff, s1_valid_ff;
   logic signed [DIM_BITS-1:0] s0_w_ff, s0_h_ff;
   logic [UW-1:0]              s1_w_ff, s1_h_ff;

   // snap
   logic [UW:0]   a_w, a_h, na_w, na_h;
   logic [UW-1:0] mag_w, mag_h;
   logic          neg_w, neg_h;
   logic          sn_valid;
   logic [HALF_W-1:0] sn_rem_w, sn_rem_h;
   logic [UW-1:0] sn_qw, sn_qh;
   logic [2*UW+1:0] sn_pay;
   logic [0:0]    sn_pay_h;

   assign a_w   = {1'b0, s1_w_ff} - (UW+1)'(base_w);
   assign a_h   = {1'b0, s1_h_ff} - (UW+1)'(base_h);
   assign na_w  = (UW+1)'(0) - a_w;
   assign na_h  = (UW+1)'(0) - a_h;
   assign neg_w = a_w[UW];
   assign neg_h = a_h[UW];
   assign mag_w = neg_w ? na_w[UW-1:0] : a_w[UW-1:0];
   assign mag_h = neg_h ? na_h[UW-1:0] : a_h[UW-1:0];

   wshc_div #(.NUM_W(UW), .PAY_W(2*UW+2)) u_snap_w (
      .clock, .reset, .en(adv), .in_valid(s1_valid_ff), .num(mag_w), .den(inc_w),
      .in_pay({neg_w, neg_h, s1_w_ff, s1_h_ff}), .out_valid(sn_valid), .quo(sn_qw),
      .rem(sn_rem_w), .out_pay(sn_pay));
   wshc_div #(.NUM_W(UW), .PAY_W(1)) u_snap_h (
      .clock, .reset, .en(adv), .in_valid(s1_valid_ff), .num(mag_h), .den(inc_h),
      .in_pay(1'b0), .out_valid(), .quo(sn_qh), .rem(sn_rem_h), .out_pay(sn_pay_h));

   // stage 2: snapped size; stage 3: aspect products
   logic              s2_valid_ff, s3_valid_ff;
   logic [UW-1:0]     s2_w_ff, s2_h_ff, s3_w_ff, s3_h_ff;
   logic [M1-1:0]     s3_pa_ff, s3_pb_ff;
   logic              c1;
   logic [UW-1:0]     sn_cw, sn_ch;

   assign sn_cw = sn_pay[2*UW-1:UW];
   assign sn_ch = sn_pay[UW-1:0];
   assign c1    = asp1_on && (s3_pa_ff > s3_pb_ff);

   logic              q1_valid;
   logic [M1-1:0]     q1, q2;
   logic [HALF_W-1:0] q1_rem, q2_rem;
   logic [2*UW:0]     q1_pay;
   logic [0:0]        q2_pay;

   wshc_div #(.NUM_W(M1), .PAY_W(2*UW+1)) u_asp1_w (
      .clock, .reset, .en(adv), .in_valid(s3_valid_ff), .num(s3_pa_ff), .den(ay),
      .in_pay({c1, s3_w_ff, s3_h_ff}), .out_valid(q1_valid), .quo(q1), .rem(q1_rem),
      .out_pay(q1_pay));
   wshc_div #(.NUM_W(M1), .PAY_W(1)) u_asp1_h (
      .clock, .reset, .en(adv), .in_valid(s3_valid_ff), .num(s3_pb_ff), .den(ax),
      .in_pay(1'b0), .out_valid(), .quo(q2), .rem(q2_rem), .out_pay(q2_pay));

   // stage 4: distances to the aspect bound
   logic              s4_valid_ff, s4_c1_ff;
   logic [UW-1:0]     s4_w_ff, s4_h_ff;
   logic [M1-1:0]     s4_d_ff, s4_e_ff;

   logic              m1_valid;
   logic [M1-1:0]     m1_q, m2_q, m2_pay;
   logic [HALF_W-1:0] m1_rem, m2_rem;
   logic [M1+2*UW:0]  m1_pay;

   wshc_div #(.NUM_W(M1), .PAY_W(M1+2*UW+1)) u_mod1_w (
      .clock, .reset, .en(adv), .in_valid(s4_valid_ff), .num(s4_d_ff), .den(inc_w),
      .in_pay({s4_c1_ff, s4_w_ff, s4_h_ff, s4_d_ff}), .out_valid(m1_valid), .quo(m1_q),
      .rem(m1_rem), .out_pay(m1_pay));
   wshc_div #(.NUM_W(M1), .PAY_W(M1)) u_mod1_h (
      .clock, .reset, .en(adv), .in_valid(s4_valid_ff), .num(s4_e_ff), .den(inc_h),
      .in_pay(s4_e_ff), .out_valid(), .quo(m2_q), .rem(m2_rem), .out_pay(m2_pay));

   // stage 5: step-aligned deltas; stage 6: first aspect correction
   logic              s5_valid_ff, s5_c1_ff, s6_valid_ff;
   logic [UW-1:0]     s5_w_ff, s5_h_ff, s6_h_ff;
   logic [M1-1:0]     s5_dw_ff, s5_dh_ff;
   logic [A-1:0]      s6_w_ff;
   logic [XW-1:0]     sum1, low1;
   logic              fit1, low_ok1;

   assign sum1    = XW'(s5_w_ff) + XW'(s5_dw_ff);
   assign low1    = XW'(s5_h_ff) - XW'(s5_dh_ff);
   assign fit1    = sum1 <= lim_w;
   assign low_ok1 = low1 >= XW'(min_h);

   // stage 7: second aspect products
   logic              s7_valid_ff;
   logic [A-1:0]      s7_w_ff;
   logic [UW-1:0]     s7_h_ff;
   logic [M2-1:0]     s7_pc_ff, s7_pd_ff;
   logic              c2;

   assign c2 = asp2_on && (s7_pd_ff < s7_pc_ff);

   logic              q3_valid;
   logic [M2-1:0]     q3, q4;
   logic [HALF_W-1:0] q3_rem, q4_rem;
   logic [A+UW:0]     q3_pay;
   logic [0:0]        q4_pay;

   wshc_div #(.NUM_W(M2), .PAY_W(A+UW+1)) u_asp2_h (
      .clock, .reset, .en(adv), .in_valid(s7_valid_ff), .num(s7_pc_ff), .den(bx),
      .in_pay({c2, s7_w_ff, s7_h_ff}), .out_valid(q3_valid), .quo(q3), .rem(q3_rem),
      .out_pay(q3_pay));
   wshc_div #(.NUM_W(M2), .PAY_W(1)) u_asp2_w (
      .clock, .reset, .en(adv), .in_valid(s7_valid_ff), .num(s7_pd_ff), .den(by),
      .in_pay(1'b0), .out_valid(), .quo(q4), .rem(q4_rem), .out_pay(q4_pay));

   // stage 8: distances to the second bound
   logic              s8_valid_ff, s8_c2_ff;
   logic [A-1:0]      s8_w_ff;
   logic [UW-1:0]     s8_h_ff;
   logic [M2-1:0]     s8_f_ff, s8_g_ff;

   logic              m3_valid;
   logic [M2-1:0]     m3_q, m4_q, m4_pay;
   logic [HALF_W-1:0] m3_rem, m4_rem;
   logic [M2+A+UW:0]  m3_pay;

   wshc_div #(.NUM_W(M2), .PAY_W(M2+A+UW+1)) u_mod2_h (
      .clock, .reset, .en(adv), .in_valid(s8_valid_ff), .num(s8_f_ff), .den(inc_h),
      .in_pay({s8_c2_ff, s8_w_ff, s8_h_ff, s8_f_ff}), .out_valid(m3_valid), .quo(m3_q),
      .rem(m3_rem), .out_pay(m3_pay));
   wshc_div #(.NUM_W(M2), .PAY_W(M2)) u_mod2_w (
      .clock, .reset, .en(adv), .in_valid(s8_valid_ff), .num(s8_g_ff), .den(inc_w),
      .in_pay(s8_g_ff), .out_valid(), .quo(m4_q), .rem(m4_rem), .out_pay(m4_pay));

   // stage 9: deltas; stage 10: second correction; then saturate into output
   logic              s9_valid_ff, s9_c2_ff, s10_valid_ff;
   logic [A-1:0]      s9_w_ff, s10_w_ff, s10_h_ff;
   logic [UW-1:0]     s9_h_ff;
   logic [M2-1:0]     s9_dh_ff, s9_dw_ff;
   logic [XW-1:0]     sum2, low2;
   logic              fit2, low_ok2;
   logic signed [DIM_BITS-1:0] out_w_ff, out_h_ff;

   assign sum2    = XW'(s9_h_ff) + XW'(s9_dh_ff);
   assign low2    = XW'(s9_w_ff) - XW'(s9_dw_ff);
   assign fit2    = sum2 <= lim_h;
   assign low_ok2 = low2 >= XW'(min_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff  <= req_chan.valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= sn_valid;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= q1_valid;
         s5_valid_ff  <= m1_valid;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= q3_valid;
         s9_valid_ff  <= m3_valid;
         s10_valid_ff <= s9_valid_ff;
         out_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_w_ff  <= req_chan.request_width;
         s0_h_ff  <= req_chan.request_height;
         s1_w_ff  <= clamp_dim(s0_w_ff, min_w, max_ff[15:0], has_max);
         s1_h_ff  <= clamp_dim(s0_h_ff, min_h, max_ff[31:16], has_max);
         s2_w_ff  <= sn_pay[2*UW+1] ? sn_cw + UW'(sn_rem_w) : sn_cw - UW'(sn_rem_w);
         s2_h_ff  <= sn_pay[2*UW]   ? sn_ch + UW'(sn_rem_h) : sn_ch - UW'(sn_rem_h);
         s3_w_ff  <= s2_w_ff;
         s3_h_ff  <= s2_h_ff;
         s3_pa_ff <= M1'(ax) * M1'(s2_h_ff);
         s3_pb_ff <= M1'(ay) * M1'(s2_w_ff);
         s4_c1_ff <= q1_pay[2*UW];
         s4_w_ff  <= q1_pay[2*UW-1:UW];
         s4_h_ff  <= q1_pay[UW-1:0];
         s4_d_ff  <= q1 - M1'(q1_pay[2*UW-1:UW]);
         s4_e_ff  <= M1'(q1_pay[UW-1:0]) - q2;
         s5_c1_ff <= m1_pay[M1+2*UW];
         s5_w_ff  <= m1_pay[M1+2*UW-1:M1+UW];
         s5_h_ff  <= m1_pay[M1+UW-1:M1];
         s5_dw_ff <= m1_pay[M1-1:0] - M1'(m1_rem);
         s5_dh_ff <= m2_pay - M1'(m2_rem);
         s6_w_ff  <= (s5_c1_ff && fit1) ? sum1[A-1:0] : A'(s5_w_ff);
         s6_h_ff  <= (s5_c1_ff && !fit1 && low_ok1) ? low1[UW-1:0] : s5_h_ff;
         s7_w_ff  <= s6_w_ff;
         s7_h_ff  <= s6_h_ff;
         s7_pc_ff <= M2'(by) * M2'(s6_w_ff);
         s7_pd_ff <= M2'(bx) * M2'(s6_h_ff);
         s8_c2_ff <= q3_pay[A+UW];
         s8_w_ff  <= q3_pay[A+UW-1:UW];
         s8_h_ff  <= q3_pay[UW-1:0];
         s8_f_ff  <= q3 - M2'(q3_pay[UW-1:0]);
         s8_g_ff  <= M2'(q3_pay[A+UW-1:UW]) - q4;
         s9_c2_ff <= m3_pay[M2+A+UW];
         s9_w_ff  <= m3_pay[M2+A+UW-1:M2+UW];
         s9_h_ff  <= m3_pay[M2+UW-1:M2];
         s9_dh_ff <= m3_pay[M2-1:0] - M2'(m3_rem);
         s9_dw_ff <= m4_pay - M2'(m4_rem);
         s10_h_ff <= (s9_c2_ff && fit2) ? sum2[A-1:0] : A'(s9_h_ff);
         s10_w_ff <= (s9_c2_ff && !fit2 && low_ok2) ? low2[A-1:0] : s9_w_ff;
         out_w_ff <= (s10_w_ff > OUT_MAX) ? OUT_MAX[DIM_BITS-1:0] : s10_w_ff[DIM_BITS-1:0];
         out_h_ff <= (s10_h_ff > OUT_MAX) ? OUT_MAX[DIM_BITS-1:0] : s10_h_ff[DIM_BITS-1:0];
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.legal_width  = out_w_ff;
   assign rsp_chan.legal_height = out_h_ff;

`ifndef SYNTHESIS
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s1_valid_ff) && $stable(s10_valid_ff))
      else $error("pipeline moved while stalled");
   a_snap_rem: assert property (@(posedge clock) disable iff (reset)
      sn_valid |-> (sn_rem_w < inc_w) && (sn_rem_h < inc_h))
      else $error("snap remainder not below step");
   a_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !rsp_chan.legal_width[DIM_BITS-1] && !rsp_chan.legal_height[DIM_BITS-1])
      else $error("negative legal size");
`endif

endmodule

// ===== sim/window_size_hint_constrain_top_test.sv =====
// Self-checking test of window_size_hint_constrain_top: size requests under
// programmed size hints, checked against a built-in legal-size predictor.
// Depends on wshc_pkg, wshc_req_if, wshc_rsp_if and the block RTL.
`timescale 1ns / 100ps

class size_scoreboard;
   logic [31:0] hints [7];
   logic [15:0] want_w [$];
   logic [15:0] want_h [$];
   int errors;

   function new();
      hints[0] = 0;
      hints[1] = 32'h0001_0001;
      hints[2] = 0;
      hints[3] = 32'h7FFF_7FFF;
      hints[4] = 32'h0001_0001;
      hints[5] = 32'h0001_0001;
      hints[6] = 32'h0001_0001;
      errors = 0;
   endfunction

   function longint trunc_mult(longint a, longint s);
      return (a / s) * s;
   endfunction

   function logic [15:0] sat16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function longint lo(logic [31:0] r);
      return longint'(r[15:0]);
   endfunction

   function longint hi(logic [31:0] r);
      return longint'(r[31:16]);
   endfunction

   function void note_request(logic signed [15:0] rw, logic signed [15:0] rh);
      longint w, h, mnw, mnh, bw, bh, mxw, mxh, iw, ih, d, ax, ay, bx, by;
      logic [4:0] f;
      f = hints[0][4:0];
      w = rw;
      h = rh;
      if (f[0]) begin
         mnw = lo(hints[1]); mnh = hi(hints[1]);
      end else if (f[4]) begin
         mnw = lo(hints[2]); mnh = hi(hints[2]);
      end else begin
         mnw = 1; mnh = 1;
      end
      if (f[4]) begin
         bw = lo(hints[2]); bh = hi(hints[2]);
      end else if (f[0]) begin
         bw = lo(hints[1]); bh = hi(hints[1]);
      end else begin
         bw = 0; bh = 0;
      end
      if (f[1]) begin
         mxw = lo(hints[3]); mxh = hi(hints[3]);
      end else begin
         mxw = 64'sd1 << 40; mxh = 64'sd1 << 40;
      end
      if (f[2]) begin
         iw = lo(hints[4]); ih = hi(hints[4]);
      end else begin
         iw = 1; ih = 1;
      end
      if (iw == 0) iw = 1;
      if (ih == 0) ih = 1;
      if (w < mnw) w = mnw;
      if (h < mnh) h = mnh;
      if (w > mxw) w = mxw;
      if (h > mxh) h = mxh;
      w = trunc_mult(w - bw, iw) + bw;
      h = trunc_mult(h - bh, ih) + bh;
      if (f[3]) begin
         ax = lo(hints[5]); ay = hi(hints[5]);
         bx = lo(hints[6]); by = hi(hints[6]);
         if (ax != 0 && ay != 0 && ax * h > ay * w) begin
            d = trunc_mult(ax * h / ay - w, iw);
            if (w + d <= mxw) w += d;
            else begin
               d = trunc_mult(h - w * ay / ax, ih);
               if (h - d >= mnh) h -= d;
            end
         end
         if (bx != 0 && by != 0 && bx * h < by * w) begin
            d = trunc_mult(w * by / bx - h, ih);
            if (h + d <= mxh) h += d;
            else begin
               d = trunc_mult(w - bx * h / by, iw);
               if (w - d >= mnw) w -= d;
            end
         end
      end
      want_w.push_back(sat16(w));
      want_h.push_back(sat16(h));
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_word(logic [15:0] gw, logic [15:0] gh);
      logic [15:0] ew, eh;
      if (want_w.size() == 0) begin
         report($sformatf("unexpected word %h %h", gw, gh));
      end else begin
         ew = want_w.pop_front();
         eh = want_h.pop_front();
         if (gw !== ew) report($sformatf("width got %h want %h", gw, ew));
         if (gh !== eh) report($sformatf("height got %h want %h", gh, eh));
      end
   endtask
endclass

module window_size_hint_constrain_top_test;
   import wshc_pkg::*;

   localparam int LATENCY = 205;
   localparam int STALL_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int idle_cycles = 0;
   bit rsp_busy = 0;

   wshc_req_if #(.DIM_BITS(16)) req_chan ();
   wshc_rsp_if #(.DIM_BITS(16)) rsp_chan ();

   size_scoreboard sb = new();

   window_size_hint_constrain_top #(.DIM_BITS(16)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.request_width = 0;
      req_chan.request_height = 0;
      rsp_chan.ready = 0;
   end

   function int gap_len();
      if ($urandom_range(0, 99) < 3) return $urandom_range(20, 80);
      if ($urandom_range(0, 99) < 50) return 0;
      return $urandom_range(1, 3);
   endfunction

   // sink side: random back-pressure, quiet stretches without it
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_word(rsp_chan.legal_width, rsp_chan.legal_height);
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.request_width, req_chan.request_height);
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         rsp_chan.ready <= rsp_busy ? 1'b1 : ($urandom_range(0, 99) < 70);
      end
   end

   always @(posedge clock) begin
      if (idle_cycles > STALL_LIMIT) begin
         $display("window_size_hint_constrain_top_test: errors");
         $finish;
      end
   end

   task csr_write(csr_idx_type idx, logic [31:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.hints[idx] = (idx == CSR_HINT_FLAGS) ? (val & 32'h1F) : val;
      @(posedge clock);
   endtask

   // valid stays high after an accept so that a zero gap gives back-to-back words
   task send_word(logic [15:0] w, logic [15:0] h);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_chan.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.request_width <= w;
      req_chan.request_height <= h;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task drain();
      req_chan.valid <= 0;
      while (sb.want_w.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function logic [15:0] rand_dim();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 40));
         2: return 16'h8000 | 16'($urandom_range(0, 3));
         3: return 16'h7FFF - 16'($urandom_range(0, 3));
         default: return 16'($urandom_range(0, 1200));
      endcase
   endfunction

   function logic [31:0] rand_pair(int lim);
      logic [15:0] a, b;
      if ($urandom_range(0, 9) == 0) return $urandom;
      a = 16'($urandom_range(0, lim));
      b = 16'($urandom_range(0, lim));
      return {b, a};
   endfunction

   task program_hints(int phase);
      if (phase == 0) begin
         csr_write(CSR_HINT_FLAGS, 32'h1F);
         csr_write(CSR_MIN_SIZE, 32'hFFFF_FFFF);
         csr_write(CSR_BASE_SIZE, 32'hFFFF_FFFF);
         csr_write(CSR_MAX_SIZE, 32'hFFFF_FFFF);
         csr_write(CSR_SIZE_STEP, 32'hFFFF_FFFF);
         csr_write(CSR_LEAST_ASPECT, 32'hFFFF_FFFF);
         csr_write(CSR_MOST_ASPECT, 32'hFFFF_FFFF);
      end else if (phase == 1) begin
         csr_write(CSR_MIN_SIZE, 32'h0);
         csr_write(CSR_BASE_SIZE, 32'h0);
         csr_write(CSR_MAX_SIZE, 32'h0);
         csr_write(CSR_SIZE_STEP, 32'h0);
         csr_write(CSR_LEAST_ASPECT, 32'h0);
         csr_write(CSR_MOST_ASPECT, 32'h0);
      end else begin
         csr_write(CSR_HINT_FLAGS, $urandom_range(0, 31) | ($urandom_range(0, 3) == 0 ? 0 : 8));
         csr_write(CSR_MIN_SIZE, rand_pair(300));
         csr_write(CSR_BASE_SIZE, rand_pair(100));
         csr_write(CSR_MAX_SIZE, rand_pair(3000));
         csr_write(CSR_SIZE_STEP, rand_pair(20));
         csr_write(CSR_LEAST_ASPECT, rand_pair(20));
         csr_write(CSR_MOST_ASPECT, rand_pair(20));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset hints, then extremes of every register
      send_word(16'h0000, 16'h0000);
      send_word(16'h7FFF, 16'h8000);
      send_word(16'h8000, 16'h7FFF);
      send_word(16'hFFFF, 16'h0001);
      drain();
      program_hints(0);
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h8000, 16'h8000);
      send_word(16'h0064, 16'h0032);
      drain();
      csr_write(CSR_HINT_FLAGS, 32'h0F);
      program_hints(1);
      send_word(16'h0010, 16'h0020);
      send_word(16'hFFF0, 16'h0005);
      drain();
      csr_write(CSR_HINT_FLAGS, 32'h1F);
      csr_write(CSR_MIN_SIZE, 32'h0032_0064);
      csr_write(CSR_MAX_SIZE, 32'h0010_0010);
      csr_write(CSR_SIZE_STEP, 32'h0007_0005);
      csr_write(CSR_BASE_SIZE, 32'h0003_0002);
      csr_write(CSR_LEAST_ASPECT, 32'h0001_0004);
      csr_write(CSR_MOST_ASPECT, 32'h0001_0002);
      send_word(16'h0200, 16'h0010);
      send_word(16'h0010, 16'h0200);
      drain();
      csr_write(CSR_MAX_SIZE, 32'h0400_0400);
      csr_write(CSR_MIN_SIZE, 32'h0001_0001);
      csr_write(CSR_LEAST_ASPECT, 32'h0003_0004);
      csr_write(CSR_MOST_ASPECT, 32'h0003_0010);
      for (int i = 0; i < 8; i++) send_word(rand_dim(), rand_dim());
      drain();
      for (int p = 0; p < 26; p++) begin
         program_hints(2);
         rsp_busy = (p % 5 == 0);
         for (int i = 0; i < 75; i++) send_word(rand_dim(), rand_dim());
         drain();
      end
      rsp_busy = 0;
      if (sb.errors == 0)
         $display("window_size_hint_constrain_top_test: clean");
      else
         $display("window_size_hint_constrain_top_test: errors");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/wshc_pkg.sv
rtl/wshc_req_if.sv
rtl/wshc_rsp_if.sv
rtl/wshc_div.sv
rtl/window_size_hint_constrain_top.sv
sim/window_size_hint_constrain_top_test.sv
